// ===== rtl/core/bdrtc_pkg.sv =====
// bdrtc_pkg: shared constants, register address codes and digit helpers
// for the bcd digit rtc register bank core and its checker
// no dependencies
package bdrtc_pkg;

  localparam int unsigned FIELD_W   = 8;
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned NUM_TIME  = 6;
  localparam int unsigned TIME_IDX_W = 3;

  localparam logic [7:0] DIGIT_RADIX     = 8'd10;
  localparam logic [3:0] HOURS_TENS_MASK = 4'h3;
  localparam logic [7:0] CTRL_F_RESET    = 8'h04;

  // register address map, digit pairs occupy 0..B
  typedef enum logic [3:0] {
    ADDR_HOURS_TENS = 4'h5,
    ADDR_WEEKDAY    = 4'hC,
    ADDR_CTRL_D     = 4'hD,
    ADDR_CTRL_E     = 4'hE,
    ADDR_CTRL_F     = 4'hF
  } reg_addr_t;

  typedef enum logic {
    ACT_READ  = 1'b0,
    ACT_WRITE = 1'b1
  } action_t;

  // control d bit meanings
  localparam int unsigned CTRL_D_HOLD_BIT = 0;
  localparam int unsigned CTRL_D_SKIP_BIT = 3;

  // x / 10 for an 8-bit value, reciprocal multiply (exact for x < 1029)
  function automatic logic [4:0] div10(input logic [7:0] x);
    logic [18:0] p;
    p = {11'd0, x} * 19'd205;
    return p[15:11];
  endfunction

  // q % 10 for q <= 25
  function automatic logic [3:0] mod10_small(input logic [4:0] q);
    logic [4:0] r;
    if (q >= 5'd20) begin
      r = q - 5'd20;
    end else if (q >= 5'd10) begin
      r = q - 5'd10;
    end else begin
      r = q;
    end
    return r[3:0];
  endfunction

  function automatic logic [3:0] units_of(input logic [7:0] x);
    logic [7:0] r;
    r = x - ({3'd0, div10(x)} * DIGIT_RADIX);
    return r[3:0];
  endfunction

  function automatic logic [3:0] tens_of(input logic [7:0] x);
    return mod10_small(div10(x));
  endfunction

endpackage

// ===== rtl/core/bcd_digit_rtc_register_bank_core.sv =====
// bcd_digit_rtc_register_bank_core: 4-bit digit register view over binary time fields
// depends on bdrtc_pkg (address codes, divide-by-ten helpers)
//
// channel  | ports                         | content
// ---------+-------------------------------+------------------------------------------
// in       | in_tvalid/in_tready/in_tdata, | tuser: action (0 read, 1 write)
//          | in_tuser                      | tdata: address [3:0], write_data [7:4]
// out      | out_tvalid/out_tready/        | tdata: read_data [7:0], one per read
//          | out_tdata                     |
//
// one transfer per cycle sustained while results are taken: an access is captured
// in an input stage, decoded and applied from there, and a read result is then
// registered in the output register before it is offered
// writes give no result and never stall in the input stage; a read waits there only
// while the output register holds a result not yet taken
// synchronous active-low reset clears all time fields, weekday, control e and flags, control f to 4
module bcd_digit_rtc_register_bank_core
  import bdrtc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // address [3:0], write_data [7:4]
  input  logic       in_tuser,   // action
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // read_data [7:0]
);

  // input stage
  logic                 stg_valid_r;
  logic                 stg_write_r;
  logic [3:0]           stg_addr_r;
  logic [DIGIT_W-1:0]   stg_data_r;

  // output register
  logic                 out_valid_r;
  logic [FIELD_W-1:0]   out_data_r;

  // register bank state: seconds, minutes, hours, date, month, year
  logic [FIELD_W-1:0]   time_r [NUM_TIME];
  logic [FIELD_W-1:0]   weekday_r;
  logic                 hold_r;
  logic                 skip_r;
  logic [FIELD_W-1:0]   ctrl_e_r;
  logic [FIELD_W-1:0]   ctrl_f_r;

  logic                 stg_go;
  logic                 in_xfer;
  logic [TIME_IDX_W-1:0] time_idx;
  logic [FIELD_W-1:0]   field_sel;
  logic [DIGIT_W-1:0]   units_dig;
  logic [DIGIT_W-1:0]   tens_dig;
  logic [DIGIT_W-1:0]   tens_wr;
  logic [FIELD_W-1:0]   field_nxt;
  logic [FIELD_W-1:0]   rd_data;
  logic                 is_digit;

  // a write always retires; a read needs room in the output register
  assign stg_go    = stg_valid_r && (stg_write_r || !out_valid_r || out_tready);
  assign in_tready = !stg_valid_r || stg_go;
  assign in_xfer   = in_tvalid && in_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // digit pair decode
  assign time_idx = stg_addr_r[3:1];
  assign is_digit = (stg_addr_r < ADDR_WEEKDAY);

  always_comb begin
    case (time_idx)
      3'd0:    field_sel = time_r[0];
      3'd1:    field_sel = time_r[1];
      3'd2:    field_sel = time_r[2];
      3'd3:    field_sel = time_r[3];
      3'd4:    field_sel = time_r[4];
      default: field_sel = time_r[5];
    endcase
  end

  assign units_dig = units_of(field_sel);
  assign tens_dig  = tens_of(field_sel);

  // hours tens keeps two bits of the written digit
  assign tens_wr = (stg_addr_r == ADDR_HOURS_TENS) ? (stg_data_r & HOURS_TENS_MASK)
                                                   : stg_data_r;

  // rebuild the field from the other digit, wraps at 8 bits
  always_comb begin
    if (stg_addr_r[0]) begin
      field_nxt = {4'd0, units_dig} + ({4'd0, tens_wr} * DIGIT_RADIX);
    end else begin
      field_nxt = ({4'd0, tens_dig} * DIGIT_RADIX) + {4'd0, stg_data_r};
    end
  end

  // read mux
  always_comb begin
    unique case (stg_addr_r) inside
      ADDR_WEEKDAY: rd_data = weekday_r;
      ADDR_CTRL_D:  rd_data = {7'd0, hold_r};
      ADDR_CTRL_E:  rd_data = ctrl_e_r;
      ADDR_CTRL_F:  rd_data = ctrl_f_r;
      default:      rd_data = {4'd0, stg_addr_r[0] ? tens_dig : units_dig};
    endcase
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_tready) begin
      stg_valid_r <= in_tvalid;
    end
    if (in_xfer) begin
      stg_write_r <= in_tuser;
      stg_addr_r  <= in_tdata[3:0];
      stg_data_r  <= in_tdata[7:4];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stg_go && (stg_write_r == ACT_READ)) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (stg_go && (stg_write_r == ACT_READ)) begin
      out_data_r <= rd_data;
    end
  end

  // register bank writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TIME; i++) begin
        time_r[i] <= '0;
      end
      weekday_r <= '0;
      hold_r    <= 1'b0;
      skip_r    <= 1'b0;
      ctrl_e_r  <= '0;
      ctrl_f_r  <= CTRL_F_RESET;
    end else if (stg_go && (stg_write_r == ACT_WRITE)) begin
      unique case (stg_addr_r) inside
        ADDR_WEEKDAY: begin
          // an armed skip drops this one write
          if (!skip_r) begin
            weekday_r <= {4'd0, stg_data_r};
          end
          skip_r <= 1'b0;
        end
        ADDR_CTRL_D: begin
          if (stg_data_r[CTRL_D_HOLD_BIT]) begin
            hold_r <= 1'b1;
          end else if (stg_data_r == '0) begin
            hold_r <= 1'b0;
          end
          if (stg_data_r[CTRL_D_SKIP_BIT]) begin
            skip_r <= 1'b1;
          end
        end
        ADDR_CTRL_E: ctrl_e_r <= {4'd0, stg_data_r};
        ADDR_CTRL_F: ctrl_f_r <= {4'd0, stg_data_r};
        default: begin
          if (is_digit) begin
            time_r[time_idx] <= field_nxt;
          end
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/bdrtc_checker.sv =====
// bdrtc_checker: port-level assertions for the bcd digit rtc register bank core
// depends on bdrtc_pkg; bound into the register bank core at the end of this file
module bdrtc_checker
  import bdrtc_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] in_tdata,
  input logic       in_tuser,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  // reads taken in minus results delivered
  logic [1:0] pend_r;
  logic [1:0] pend_nxt;
  logic       rd_in;
  logic       rd_out;

  assign rd_in  = in_tvalid && in_tready && (in_tuser == ACT_READ);
  assign rd_out = out_tvalid && out_tready;

  always_comb begin
    pend_nxt = pend_r;
    if (rd_in && !rd_out) begin
      pend_nxt = pend_r + 2'd1;
    end else if (!rd_in && rd_out) begin
      pend_nxt = pend_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // a held result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // the input side stalls only behind an untaken result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without a waiting result");

  // no result without a read behind it
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> pend_r != 2'd0)
    else $error("result with no outstanding read");

  // at most one read in the input stage and one in the output register
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("too many reads in flight");

endmodule

bind bcd_digit_rtc_register_bank_core bdrtc_checker u_bdrtc_checker (.*);

// ===== bench/bcd_digit_rtc_register_bank_core_tb.sv =====
// bcd_digit_rtc_register_bank_core_tb: self-checking bench for the digit register bank core
// keeps its own model of the time fields and control flags, checks every read transfer
// depends on bdrtc_pkg and bcd_digit_rtc_register_bank_core
module bcd_digit_rtc_register_bank_core_tb;
  import bdrtc_pkg::*;

  // cycles without any transfer before the run is declared hung
  localparam int unsigned HANG_LIMIT = 2000;
  // cycles let pass after the last read result, covers the two-stage pipe
  localparam int unsigned TAIL_CYCLES = 8;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;   // address [3:0], write_data [7:4]
  logic       in_tuser = 1'b0;    // action
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;          // read_data [7:0]

  // model of the register bank
  logic [FIELD_W-1:0] time_field [NUM_TIME];  // sec, min, hours, date, month, year
  logic [FIELD_W-1:0] weekday_q;
  logic               hold_q;
  logic               skip_wday_q;
  logic [FIELD_W-1:0] ctrl_e_q;
  logic [FIELD_W-1:0] ctrl_f_q;

  // read data still owed by the block, oldest first
  logic [7:0] pending_reads [$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int rx_hold_req = 0;   // a test asks for a long receiver hold-off here
  int n_sent = 0;
  int n_reads_checked = 0;
  int n_fail = 0;
  int quiet_cycles = 0;

  bcd_digit_rtc_register_bank_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [7:0] units_digit(input logic [7:0] x);
    return x % DIGIT_RADIX;
  endfunction

  function automatic logic [7:0] tens_digit(input logic [7:0] x);
    return (x / DIGIT_RADIX) % DIGIT_RADIX;
  endfunction

  function automatic void clear_bank_model();
    foreach (time_field[i]) time_field[i] = '0;
    weekday_q   = '0;
    hold_q      = 1'b0;
    skip_wday_q = 1'b0;
    ctrl_e_q    = '0;
    ctrl_f_q    = CTRL_F_RESET;
  endfunction

  // apply one accepted access to the model, queue the read data it owes
  function automatic void apply_access(input action_t act, input logic [3:0] addr,
                                       input logic [3:0] wd);
    logic [7:0] f;
    logic [3:0] t;
    int         idx;
    idx = addr >> 1;
    if (act == ACT_READ) begin
      if (addr < ADDR_WEEKDAY) begin
        f = time_field[idx];
        pending_reads.push_back(addr[0] ? tens_digit(f) : units_digit(f));
      end else if (addr == ADDR_WEEKDAY) begin
        pending_reads.push_back(weekday_q);
      end else if (addr == ADDR_CTRL_D) begin
        pending_reads.push_back({7'd0, hold_q});
      end else if (addr == ADDR_CTRL_E) begin
        pending_reads.push_back(ctrl_e_q);
      end else begin
        pending_reads.push_back(ctrl_f_q);
      end
    end else begin
      if (addr < ADDR_WEEKDAY) begin
        f = time_field[idx];
        if (addr[0]) begin
          // hours tens digit keeps two bits only
          t = (addr == ADDR_HOURS_TENS) ? (wd & HOURS_TENS_MASK) : wd;
          time_field[idx] = units_digit(f) + t * DIGIT_RADIX;
        end else begin
          time_field[idx] = tens_digit(f) * DIGIT_RADIX + wd;
        end
      end else if (addr == ADDR_WEEKDAY) begin
        // an armed skip drops this write, then disarms either way
        if (!skip_wday_q) weekday_q = {4'd0, wd};
        skip_wday_q = 1'b0;
      end else if (addr == ADDR_CTRL_D) begin
        if (wd[CTRL_D_HOLD_BIT]) hold_q = 1'b1;
        if (wd == 4'd0) hold_q = 1'b0;
        if (wd[CTRL_D_SKIP_BIT]) skip_wday_q = 1'b1;
      end else if (addr == ADDR_CTRL_E) begin
        ctrl_e_q = {4'd0, wd};
      end else begin
        ctrl_f_q = {4'd0, wd};
      end
    end
  endfunction

  // offer one access, idling first at the sender rate; entered at a rising edge
  // valid is left high so back-to-back transfers see no dip
  task automatic send_access(input action_t act, input logic [3:0] addr,
                             input logic [3:0] wd);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {wd, addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    apply_access(act, addr, wd);
    n_sent++;
  endtask

  // sender stops offering until the block owes nothing
  task automatic wait_reads_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_reads.size() != 0) @(posedge clk);
  endtask

  task automatic read_reg(input logic [3:0] addr);
    send_access(ACT_READ, addr, 4'($urandom_range(15)));
  endtask

  task automatic test_reset_values();
    read_reg(4'h0);
    read_reg(4'hB);
    read_reg(ADDR_WEEKDAY);
    read_reg(ADDR_CTRL_D);
    read_reg(ADDR_CTRL_E);
    read_reg(ADDR_CTRL_F);
  endtask

  // digits above nine pass unchecked, hours tens is masked to two bits
  task automatic test_digit_writes();
    send_access(ACT_WRITE, 4'h0, 4'hF);
    send_access(ACT_WRITE, 4'h1, 4'hF);
    read_reg(4'h0);
    read_reg(4'h1);
    send_access(ACT_WRITE, ADDR_HOURS_TENS, 4'hF);
    read_reg(ADDR_HOURS_TENS);
  endtask

  // hold set, clear and keep; skip arming drops exactly one weekday write
  task automatic test_control_d();
    send_access(ACT_WRITE, ADDR_CTRL_D, 4'h9);
    send_access(ACT_WRITE, ADDR_WEEKDAY, 4'h7);
    read_reg(ADDR_WEEKDAY);
    read_reg(ADDR_CTRL_D);
    send_access(ACT_WRITE, ADDR_WEEKDAY, 4'h6);
    read_reg(ADDR_WEEKDAY);
    send_access(ACT_WRITE, ADDR_CTRL_D, 4'h2);
    read_reg(ADDR_CTRL_D);
    send_access(ACT_WRITE, ADDR_CTRL_D, 4'h0);
    read_reg(ADDR_CTRL_D);
  endtask

  task automatic test_control_bytes();
    send_access(ACT_WRITE, ADDR_CTRL_E, 4'hF);
    send_access(ACT_WRITE, ADDR_CTRL_F, 4'h0);
    read_reg(ADDR_CTRL_E);
    read_reg(ADDR_CTRL_F);
  endtask

  // receiver holds off while reads keep coming, so the input side must stall
  task automatic test_backpressure_fill();
    int k;
    tx_idle_pct = 0;
    rx_hold_req = 60;
    for (k = 0; k < 24; k++) read_reg(4'($urandom_range(15)));
    wait_reads_drained();
  endtask

  // mostly write-then-readback sequences with random content, the rest noise
  task automatic test_random_mix(input int n_items, input int tx_pct, input int rx_pct);
    int         stop_at;
    int         kind;
    logic [3:0] a;
    logic [3:0] v;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    stop_at = n_sent + n_items;
    while (n_sent < stop_at) begin
      kind = $urandom_range(99);
      if (kind < 40) begin
        // digit pair round trip
        a = 4'(2 * $urandom_range(NUM_TIME - 1));
        if ($urandom_range(1)) begin
          send_access(ACT_WRITE, a, 4'($urandom_range(15)));
          send_access(ACT_WRITE, a | 4'h1, 4'($urandom_range(15)));
        end else begin
          send_access(ACT_WRITE, a | 4'h1, 4'($urandom_range(15)));
          send_access(ACT_WRITE, a, 4'($urandom_range(15)));
        end
        read_reg(a);
        read_reg(a | 4'h1);
      end else if (kind < 55) begin
        // control d then weekday, exercising hold and skip
        v = 4'($urandom_range(15));
        send_access(ACT_WRITE, ADDR_CTRL_D, v);
        send_access(ACT_WRITE, ADDR_WEEKDAY, 4'($urandom_range(15)));
        read_reg(ADDR_WEEKDAY);
        read_reg(ADDR_CTRL_D);
      end else if (kind < 60) begin
        a = $urandom_range(1) ? ADDR_CTRL_E : ADDR_CTRL_F;
        send_access(ACT_WRITE, a, 4'($urandom_range(15)));
        read_reg(a);
      end else begin
        send_access(action_t'($urandom_range(1)), 4'($urandom_range(15)),
                    4'($urandom_range(15)));
      end
    end
  endtask

  // result checker and receiver ready generator
  always @(posedge clk) begin
    int   hold_cnt;
    logic [7:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_reads.size() == 0) begin
        $display("%0t unexpected read transfer: expected none actual %0h", $time, out_tdata);
        n_fail++;
      end else begin
        want = pending_reads.pop_front();
        n_reads_checked++;
        if (out_tdata !== want) begin
          $display("%0t read_data mismatch: expected %0h actual %0h", $time, want, out_tdata);
          n_fail++;
        end
      end
    end
    // a requested hold-off is counted down here
    if (rx_hold_req != 0) begin
      hold_cnt = rx_hold_req;
      rx_hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // watchdog on transfer activity
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("%0t no transfer for %0d cycles", $time, HANG_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    clear_bank_model();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part with the first idling mix
    tx_idle_pct = 23;
    rx_idle_pct = 50;
    test_reset_values();
    test_digit_writes();
    test_control_d();
    test_control_bytes();
    wait_reads_drained();
    test_backpressure_fill();

    // random part: receiver idles more, then sender idles more, then no idling
    test_random_mix(617, 23, 50);
    wait_reads_drained();
    test_random_mix(617, 50, 23);
    test_random_mix(616, 0, 0);

    wait_reads_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d accesses (directed edges, backpressure fill, random mixes)", n_sent);
    $display("checked %0d read transfers, %0d failures", n_reads_checked, n_fail);
    if (n_fail == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
